/* src/pixel_resolve_tonemap_pack_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pixel resolve / tonemap / pack unit
// ---------------------------------------------------------------------------
`ifndef PIXEL_RESOLVE_TONEMAP_PACK_UNIT_MACROS_SVH
`define PIXEL_RESOLVE_TONEMAP_PACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define PRTP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define PRTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/prtp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prtp_pkg
// Types and constants shared by the pixel resolve / tonemap / pack pipeline.
// ---------------------------------------------------------------------------
package prtp_pkg;

   // Register indexes of the configuration port
   localparam logic [3:0] REG_SAMPLES  = 4'd0;
   localparam logic [3:0] REG_TONE_EN  = 4'd1;
   localparam logic [3:0] REG_EXPOSURE = 4'd2;
   localparam logic [3:0] REG_CURVE    = 4'd3;

   // Output curve codes
   localparam logic [1:0] CURVE_SQRT  = 2'd0;
   localparam logic [1:0] CURVE_POWER = 2'd1;

   // 1.0 in Q16
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // ACES filmic coefficients in Q16
   localparam logic [17:0] ACES_A = 18'd164495;
   localparam logic [10:0] ACES_B = 11'd1966;
   localparam logic [17:0] ACES_C = 18'd159252;
   localparam logic [15:0] ACES_D = 16'd38666;
   localparam logic [13:0] ACES_E = 14'd9175;

   // Pipeline depths
   localparam int DIV_STAGES   = 32;
   localparam int ACES_STAGES  = 17;
   localparam int TONE_STAGES  = 3 + ACES_STAGES + 1;
   localparam int SQRT_STAGES  = 17;
   localparam int ROOT5_STAGES = 16;
   localparam int CURVE_STAGES = SQRT_STAGES + 1;
   localparam int PIPE_DEPTH   = DIV_STAGES + TONE_STAGES + CURVE_STAGES + 1;

   typedef struct packed {
      logic [31:0] red_sum;
      logic [31:0] green_sum;
      logic [31:0] blue_sum;
      logic [11:0] column;
      logic [11:0] row;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_value;
      logic [23:0] pixel_address;
   } rsp_type;

   // Settings seen by every lane
   typedef struct packed {
      logic [15:0] divisor;
      logic        tone_en;
      logic [15:0] gain;
      logic [1:0]  mode;
   } lane_cfg_type;

endpackage
`default_nettype wire

/* src/pixel_resolve_tonemap_pack_unit.sv */
// Pipeline: 32-stage count divide, 21 tonemap stages with a 17-stage ACES
//   divide, 18 curve stages, 1 pack stage.
// Throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output register.
// Reset: synchronous; clears the valid chain and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pixel_resolve_tonemap_pack_unit
// Resolves accumulated RGB sums into a packed 24-bit pixel and address with
// three channel lanes working side by side and a pack stage.
// ---------------------------------------------------------------------------
module pixel_resolve_tonemap_pack_unit import prtp_pkg::*; #(
   parameter int SCREEN_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam logic [12:0] SCREEN_W = 13'(SCREEN_WIDTH);

   // ---- configuration registers ----
   logic [15:0] spp_ff, gain_ff;
   logic        tone_en_ff;
   logic [1:0]  mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff     <= 16'd1;
         tone_en_ff <= 1'b0;
         gain_ff    <= 16'd256;
         mode_ff    <= CURVE_SQRT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SAMPLES:  spp_ff     <= csr_data;
            REG_TONE_EN:  tone_en_ff <= csr_data[0];
            REG_EXPOSURE: gain_ff    <= csr_data;
            REG_CURVE:    mode_ff    <= csr_data[1:0];
            default:      ;
         endcase
      end
   end

   lane_cfg_type cfg;
   assign cfg.divisor = (spp_ff == 16'd0) ? 16'd1 : spp_ff;
   assign cfg.tone_en = tone_en_ff;
   assign cfg.gain    = gain_ff;
   assign cfg.mode    = mode_ff;

   // ---- pipeline advance and valid chain ----
   logic                  adv;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;

   assign adv       = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign valid_in  = {valid_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // ---- address: compute at entry, carry along ----
   logic [23:0] addr_ff [PIPE_DEPTH];
   logic [23:0] addr_in;

   assign addr_in = 24'(25'(req_payload.row) * 25'(SCREEN_W) + 25'(req_payload.column));

   for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_addr
      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (adv) begin
               addr_ff[i] <= addr_in;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (adv) begin
               addr_ff[i] <= addr_ff[i-1];
            end
         end
      end
   end

   // ---- channel lanes ----
   logic [16:0] red_tone, green_tone, blue_tone;
   logic [16:0] red_curve, green_curve, blue_curve;
   logic [16:0] green_root;

   prtp_lane u_lane_red (
      .clock     (clock),
      .adv       (adv),
      .cfg       (cfg),
      .sum_in    (req_payload.red_sum),
      .tone_out  (red_tone),
      .curve_out (red_curve)
   );

   prtp_lane u_lane_green (
      .clock     (clock),
      .adv       (adv),
      .cfg       (cfg),
      .sum_in    (req_payload.green_sum),
      .tone_out  (green_tone),
      .curve_out (green_curve)
   );

   prtp_lane u_lane_blue (
      .clock     (clock),
      .adv       (adv),
      .cfg       (cfg),
      .sum_in    (req_payload.blue_sum),
      .tone_out  (blue_tone),
      .curve_out (blue_curve)
   );

   // green's 0.8 power runs beside its square-root stages
   prtp_root5 u_root5 (
      .clock    (clock),
      .adv      (adv),
      .v_in     (green_tone),
      .root_out (green_root)
   );

   // ---- pack ----
   logic [23:0] pixel;

   prtp_merge u_merge (
      .clock      (clock),
      .adv        (adv),
      .mode       (mode_ff),
      .red_v      (red_curve),
      .green_v    (green_curve),
      .green_root (green_root),
      .blue_v     (blue_curve),
      .pixel_out  (pixel)
   );

   assign rsp_valid                 = valid_ff[PIPE_DEPTH-1];
   assign rsp_payload.pixel_value   = pixel;
   assign rsp_payload.pixel_address = addr_ff[PIPE_DEPTH-1];

   // red and blue taps feed nothing beyond their own lanes
   logic unused_tone;
   assign unused_tone = ^{red_tone, blue_tone};

endmodule
`default_nettype wire

/* src/prtp_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prtp_lane
// One color channel: sample-count divide, exposure and ACES fit, square
// root, power-1.5 or pass-through curve. Every stage advances on adv.
// ---------------------------------------------------------------------------
module prtp_lane import prtp_pkg::*; (
   input  logic         clock,
   input  logic         adv,
   input  lane_cfg_type cfg,
   input  logic [31:0]  sum_in,
   output logic [16:0]  tone_out,
   output logic [16:0]  curve_out
);

   // ---- sample-count divide, one quotient bit per stage ----
   logic [15:0] drem_ff [DIV_STAGES];
   logic [31:0] dquo_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [15:0] rem_prev;
      logic [31:0] quo_prev;
      logic [16:0] trial;
      logic        ge;
      logic [15:0] rem_in;
      logic [31:0] quo_in;
      if (k == 0) begin : g_head
         assign rem_prev = '0;
         assign quo_prev = sum_in;
      end else begin : g_body
         assign rem_prev = drem_ff[k-1];
         assign quo_prev = dquo_ff[k-1];
      end
      assign trial  = {rem_prev, quo_prev[31]};
      assign ge     = trial >= {1'b0, cfg.divisor};
      assign rem_in = ge ? 16'(trial - {1'b0, cfg.divisor}) : trial[15:0];
      assign quo_in = {quo_prev[30:0], ge};
      always_ff @(posedge clock) begin
         if (adv) begin
            drem_ff[k] <= rem_in;
            dquo_ff[k] <= quo_in;
         end
      end
   end

   // ---- exposure product and clamped bypass value ----
   logic [31:0] avg;
   logic [47:0] prod_ff, prod_in;
   logic [16:0] byp1_ff, byp1_in;

   assign avg     = dquo_ff[DIV_STAGES-1];
   assign prod_in = 48'(avg) * 48'(cfg.gain);
   assign byp1_in = (avg > {15'd0, ONE_Q16}) ? ONE_Q16 : avg[16:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         byp1_ff <= byp1_in;
      end
   end

   // ---- square of t; flag t of 16.0 or more ----
   logic [19:0] t_ff, t_in;
   logic [39:0] sq_ff, sq_in;
   logic        sat2_ff, sat2_in;
   logic [16:0] byp2_ff;

   assign t_in    = prod_ff[27:8];
   assign sat2_in = |prod_ff[47:28];
   assign sq_in   = 40'(t_in) * 40'(t_in);

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff    <= t_in;
         sq_ff   <= sq_in;
         sat2_ff <= sat2_in;
         byp2_ff <= byp1_ff;
      end
   end

   // ---- numerator and denominator of the rational fit ----
   logic [58:0] num_full, den_full;
   logic [42:0] num_ff, den_ff;
   logic        sat3_ff;
   logic [16:0] byp3_ff;

   assign num_full = 59'(ACES_A) * 59'(sq_ff) + ((59'(ACES_B) * 59'(t_ff)) << 16);
   assign den_full = 59'(ACES_C) * 59'(sq_ff) + ((59'(ACES_D) * 59'(t_ff)) << 16)
                   + (59'(ACES_E) << 32);

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff  <= num_full[58:16];
         den_ff  <= den_full[58:16];
         sat3_ff <= sat2_ff;
         byp3_ff <= byp2_ff;
      end
   end

   // ---- fit quotient, one bit per stage (quotient stays below 2.0) ----
   logic [43:0] arem_ff [ACES_STAGES];
   logic [42:0] aden_ff [ACES_STAGES];
   logic [16:0] aq_ff   [ACES_STAGES];
   logic        asat_ff [ACES_STAGES];
   logic [16:0] abyp_ff [ACES_STAGES];

   for (genvar k = 0; k < ACES_STAGES; k++) begin : g_aces
      logic [43:0] rem_prev;
      logic [42:0] den_prev;
      logic [16:0] q_prev;
      logic        sat_prev;
      logic [16:0] byp_prev;
      logic        ge;
      logic [43:0] diff;
      if (k == 0) begin : g_head
         assign rem_prev = {1'b0, num_ff};
         assign den_prev = den_ff;
         assign q_prev   = '0;
         assign sat_prev = sat3_ff;
         assign byp_prev = byp3_ff;
      end else begin : g_body
         assign rem_prev = arem_ff[k-1];
         assign den_prev = aden_ff[k-1];
         assign q_prev   = aq_ff[k-1];
         assign sat_prev = asat_ff[k-1];
         assign byp_prev = abyp_ff[k-1];
      end
      assign ge   = rem_prev >= {1'b0, den_prev};
      assign diff = ge ? rem_prev - {1'b0, den_prev} : rem_prev;
      always_ff @(posedge clock) begin
         if (adv) begin
            arem_ff[k] <= {diff[42:0], 1'b0};
            aden_ff[k] <= den_prev;
            aq_ff[k]   <= {q_prev[15:0], ge};
            asat_ff[k] <= sat_prev;
            abyp_ff[k] <= byp_prev;
         end
      end
   end

   // ---- pick tonemapped or plain average, clamped to 1.0 ----
   logic [16:0] qa, aces_v;
   logic [16:0] tone_ff, tone_in;

   assign qa      = aq_ff[ACES_STAGES-1];
   assign aces_v  = (asat_ff[ACES_STAGES-1] || qa > ONE_Q16) ? ONE_Q16 : qa;
   assign tone_in = cfg.tone_en ? aces_v : abyp_ff[ACES_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         tone_ff <= tone_in;
      end
   end

   assign tone_out = tone_ff;

   // ---- square root of v in Q16, one result bit per stage ----
   logic [33:0] sx_ff [SQRT_STAGES];
   logic [33:0] sr_ff [SQRT_STAGES];
   logic [16:0] sv_ff [SQRT_STAGES];

   for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
      localparam logic [33:0] SQ_BIT = 34'd1 << (32 - 2 * j);
      logic [33:0] x_prev;
      logic [33:0] r_prev;
      logic [16:0] v_prev;
      logic [33:0] trial;
      logic        ge;
      if (j == 0) begin : g_head
         assign x_prev = {1'b0, tone_ff, 16'd0};
         assign r_prev = '0;
         assign v_prev = tone_ff;
      end else begin : g_body
         assign x_prev = sx_ff[j-1];
         assign r_prev = sr_ff[j-1];
         assign v_prev = sv_ff[j-1];
      end
      assign trial = r_prev + SQ_BIT;
      assign ge    = x_prev >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[j] <= ge ? x_prev - trial : x_prev;
            sr_ff[j] <= ge ? (r_prev >> 1) + SQ_BIT : r_prev >> 1;
            sv_ff[j] <= v_prev;
         end
      end
   end

   // ---- apply the output curve ----
   logic [16:0] root, vv;
   logic [33:0] p15;
   logic [16:0] curve_ff, curve_in;

   assign root = sr_ff[SQRT_STAGES-1][16:0];
   assign vv   = sv_ff[SQRT_STAGES-1];
   assign p15  = 34'(vv) * 34'(root);

   always_comb begin
      case (cfg.mode)
         CURVE_SQRT:  curve_in = root;
         CURVE_POWER: curve_in = p15[32:16];
         default:     curve_in = vv;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         curve_ff <= curve_in;
      end
   end

   assign curve_out = curve_ff;

endmodule
`default_nettype wire

/* src/prtp_root5.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prtp_root5
// Power 0.8 curve: largest y with y^5 <= v^4 * 2^16, one bit per stage.
// Powers of the trial root grow by binomial terms, so each stage only shifts
// and adds.
// ---------------------------------------------------------------------------
module prtp_root5 import prtp_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [16:0] v_in,
   output logic [16:0] root_out
);

   // ---- v squared, then v to the fourth ----
   logic        big1_ff, big2_ff;
   logic [31:0] v2_ff;
   logic [63:0] v4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         big1_ff <= v_in[16];
         v2_ff   <= 32'(v_in[15:0]) * 32'(v_in[15:0]);
         big2_ff <= big1_ff;
         v4_ff   <= 64'(v2_ff) * 64'(v2_ff);
      end
   end

   // ---- bit-by-bit fifth root ----
   logic [15:0] y_ff   [ROOT5_STAGES];
   logic [31:0] y2_ff  [ROOT5_STAGES];
   logic [47:0] y3_ff  [ROOT5_STAGES];
   logic [63:0] y4_ff  [ROOT5_STAGES];
   logic [79:0] y5_ff  [ROOT5_STAGES];
   logic [79:0] lim_ff [ROOT5_STAGES];
   logic        big_ff [ROOT5_STAGES];

   for (genvar k = 0; k < ROOT5_STAGES; k++) begin : g_root
      localparam int SH = ROOT5_STAGES - 1 - k;
      logic [15:0] yp;
      logic [31:0] y2p, y2t;
      logic [47:0] y3p, y3t;
      logic [63:0] y4p, y4t;
      logic [79:0] y5p, y5t;
      logic [79:0] limp;
      logic        bigp;
      logic        ok;
      if (k == 0) begin : g_head
         assign yp   = '0;
         assign y2p  = '0;
         assign y3p  = '0;
         assign y4p  = '0;
         assign y5p  = '0;
         assign limp = {v4_ff, 16'd0};
         assign bigp = big2_ff;
      end else begin : g_body
         assign yp   = y_ff[k-1];
         assign y2p  = y2_ff[k-1];
         assign y3p  = y3_ff[k-1];
         assign y4p  = y4_ff[k-1];
         assign y5p  = y5_ff[k-1];
         assign limp = lim_ff[k-1];
         assign bigp = big_ff[k-1];
      end
      assign y2t = y2p + (32'(yp) << (SH + 1)) + (32'd1 << (2 * SH));
      assign y3t = y3p + ((48'(y2p) * 48'd3) << SH) + ((48'(yp) * 48'd3) << (2 * SH))
                 + (48'd1 << (3 * SH));
      assign y4t = y4p + ((64'(y3p) * 64'd4) << SH) + ((64'(y2p) * 64'd6) << (2 * SH))
                 + ((64'(yp) * 64'd4) << (3 * SH)) + (64'd1 << (4 * SH));
      assign y5t = y5p + ((80'(y4p) * 80'd5) << SH) + ((80'(y3p) * 80'd10) << (2 * SH))
                 + ((80'(y2p) * 80'd10) << (3 * SH)) + ((80'(yp) * 80'd5) << (4 * SH))
                 + (80'd1 << (5 * SH));
      assign ok  = y5t <= limp;
      always_ff @(posedge clock) begin
         if (adv) begin
            y_ff[k]   <= ok ? (yp | (16'd1 << SH)) : yp;
            y2_ff[k]  <= ok ? y2t : y2p;
            y3_ff[k]  <= ok ? y3t : y3p;
            y4_ff[k]  <= ok ? y4t : y4p;
            y5_ff[k]  <= ok ? y5t : y5p;
            lim_ff[k] <= limp;
            big_ff[k] <= bigp;
         end
      end
   end

   // 1.0 and above map to 1.0
   assign root_out = big_ff[ROOT5_STAGES-1] ? ONE_Q16 : {1'b0, y_ff[ROOT5_STAGES-1]};

endmodule
`default_nettype wire

/* src/prtp_merge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// prtp_merge
// Combine the three lanes: pick the green curve, scale each channel to a
// byte and pack 0xRRGGBB into the output register.
// ---------------------------------------------------------------------------
module prtp_merge import prtp_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [1:0]  mode,
   input  logic [16:0] red_v,
   input  logic [16:0] green_v,
   input  logic [16:0] green_root,
   input  logic [16:0] blue_v,
   output logic [23:0] pixel_out
);

   // floor(255 * v / 65536) for v up to 1.0
   function automatic logic [7:0] to_byte(input logic [16:0] v);
      logic [24:0] s;
      s = {v, 8'd0} - {8'd0, v};
      return s[23:16];
   endfunction

   logic [16:0] green_sel;
   logic [23:0] pixel_ff, pixel_in;

   // green takes the 0.8 power under the power curve
   assign green_sel = (mode == CURVE_POWER) ? green_root : green_v;
   assign pixel_in  = {to_byte(red_v), to_byte(green_sel), to_byte(blue_v)};

   always_ff @(posedge clock) begin
      if (adv) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel_out = pixel_ff;

endmodule
`default_nettype wire

/* src/prtp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_resolve_tonemap_pack_unit_macros.svh"
// ---------------------------------------------------------------------------
// prtp_checker
// Port-level checks on flow control of the pixel resolve unit.
// ---------------------------------------------------------------------------
module prtp_checker import prtp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload,
   input logic    csr_valid,
   input logic    csr_ready
);

   logic unused_req;
   assign unused_req = req_valid;

   // hold a stalled result item
   `PRTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result item changed")
   // freeze intake while the output item waits
   `PRTP_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready, "item taken during output stall")
   // advance whenever the output slot drains
   `PRTP_ASSERT_IMPLY(a_drain_ready, clock, reset, !rsp_valid || rsp_ready, req_ready, "intake blocked with free output")
   // take register writes at once
   `PRTP_ASSERT_IMPLY(a_csr_ready, clock, reset, csr_valid, csr_ready, "register write refused")

endmodule

bind pixel_resolve_tonemap_pack_unit prtp_checker u_prtp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready)
);
`default_nettype wire

/* verif/pixel_resolve_tonemap_pack_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pixel_resolve_tonemap_pack_unit_tb
// Self-checking bench for the pixel resolve / tonemap / pack unit. Runs
// several register settings, predicts each packed pixel and address in
// fixed point, and checks results in order under random gaps and stalls.
// ---------------------------------------------------------------------------
module pixel_resolve_tonemap_pack_unit_tb;
   import prtp_pkg::*;

   localparam int          SCREEN_W    = 1024;
   localparam logic [1:0]  CURVE_PASS  = 2'd2;
   localparam logic [1:0]  CURVE_SPARE = 2'd3;
   localparam longint      ONE         = 64'd65536;
   localparam int          DRAIN_WAIT  = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   // register copy used for prediction
   logic [15:0] samples_q = 16'd1;
   logic        tone_en_q = 1'b0;
   logic [15:0] gain_q    = 16'd256;
   logic [1:0]  curve_q   = CURVE_SQRT;

   req_type pending_items[$];
   rsp_type expected_pixels[$];
   int      error_count = 0;

   pixel_resolve_tonemap_pack_unit #(.SCREEN_WIDTH(SCREEN_W)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // integer square root, bit by bit
   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned root, b;
      root = 0;
      b = 64'd1 << 32;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= root + b) begin
            x = x - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // v^0.8 in Q16: largest y with y^5 <= v^4 * 2^16
   function automatic longint unsigned pow_four_fifths(input longint unsigned v);
      logic [127:0] bound, y5;
      logic [15:0]  y;
      logic [15:0]  trial;
      if (v >= ONE) return ONE;
      bound = (128'(v) * v * v * v) << 16;
      y = '0;
      for (int i = 15; i >= 0; i--) begin
         trial = y | (16'd1 << i);
         y5 = 128'(trial) * trial * trial * trial * trial;
         if (y5 <= bound) y = trial;
      end
      return longint'(y);
   endfunction

   // ACES filmic fit, clamped to 1.0
   function automatic longint unsigned aces_fit(input longint unsigned t);
      longint unsigned t2, num, den, q;
      if (t >= (64'd16 << 16)) return ONE;
      t2  = t * t;
      num = (64'd164495 * t2 + ((64'd1966 * t) << 16)) >> 16;
      den = (64'd159252 * t2 + ((64'd38666 * t) << 16) + (64'd9175 << 32)) >> 16;
      q   = (num << 16) / den;
      return (q > ONE) ? ONE : q;
   endfunction

   // resolve one channel sum to its 8-bit level
   function automatic logic [7:0] channel_level(input logic [31:0] sum,
                                                input bit green);
      longint unsigned n, v;
      n = (samples_q == 0) ? 64'd1 : 64'(samples_q);
      v = 64'(sum) / n;
      if (tone_en_q) v = aces_fit((v * gain_q) >> 8);
      if (v > ONE) v = ONE;
      if (curve_q == CURVE_SQRT) begin
         v = int_sqrt(v << 16);
      end else if (curve_q == CURVE_POWER) begin
         if (green) v = pow_four_fifths(v);
         else       v = (v * int_sqrt(v << 16)) >> 16;
      end
      if (v > ONE) v = ONE;
      return 8'((64'd255 * v) >> 16);
   endfunction

   function automatic rsp_type resolve_pixel(input req_type item);
      rsp_type r;
      r.pixel_value   = {channel_level(item.red_sum, 1'b0),
                         channel_level(item.green_sum, 1'b1),
                         channel_level(item.blue_sum, 1'b0)};
      r.pixel_address = 24'(32'(item.column) + 32'(item.row) * SCREEN_W);
      return r;
   endfunction

   // random sum: extremes, small averages or averages up to 2.0 at the current sample count
   function automatic logic [31:0] random_sum();
      longint unsigned n, s;
      int kind;
      kind = $urandom_range(0, 9);
      n = (samples_q == 0) ? 64'd1 : 64'(samples_q);
      if (kind == 0) return $urandom;
      if (kind == 1) return 32'd0;
      if (kind == 2) return 32'hFFFF_FFFF;
      if (kind < 5) s = 64'($urandom_range(0, 1024)) * n;
      else s = 64'($urandom_range(0, 2 * 65536)) * n;
      s = s + 64'($urandom_range(0, int'(n - 1)));
      return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic req_type random_item();
      req_type item;
      item.red_sum   = random_sum();
      item.green_sum = random_sum();
      item.blue_sum  = random_sum();
      item.column    = 12'($urandom);
      item.row       = 12'($urandom);
      return item;
   endfunction

   function automatic req_type make_item(input logic [31:0] r, input logic [31:0] g,
                                         input logic [31:0] b, input logic [11:0] c,
                                         input logic [11:0] w);
      req_type item;
      item.red_sum = r; item.green_sum = g; item.blue_sum = b;
      item.column = c; item.row = w;
      return item;
   endfunction

   // write one register; caller is at a clock edge and lowers valid afterward
   task automatic write_reg(input logic [3:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_SAMPLES:  samples_q = value;
         REG_TONE_EN:  tone_en_q = value[0];
         REG_EXPOSURE: gain_q    = value;
         REG_CURVE:    curve_q   = value[1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] n, input logic en,
                                 input logic [15:0] g, input logic [1:0] c);
      write_reg(REG_SAMPLES, n);
      write_reg(REG_TONE_EN, {15'd0, en});
      write_reg(REG_EXPOSURE, g);
      write_reg(REG_CURVE, {14'd0, c});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every item to come back; sample between edges so that the
   // driver and monitor updates of the same edge are already visible
   task automatic drain();
      @(negedge clock);
      while (pending_items.size() != 0 || expected_pixels.size() != 0 || req_valid)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // driver: bursts of items separated by random gaps
   int burst_left = 0;
   int gap_left   = 0;
   always @(posedge clock) begin
      logic    next_valid;
      req_type next_item;
      next_valid = 1'b0;
      next_item  = req_payload;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_pixels.push_back(resolve_pixel(req_payload));
         if (req_valid && !req_ready) begin
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (pending_items.size() != 0) begin
            next_item  = pending_items.pop_front();
            next_valid = 1'b1;
            if (burst_left > 0) begin
               burst_left = burst_left - 1;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
      end
      req_valid   <= next_valid;
      req_payload <= next_item;
   end

   // monitor: stall on a slowly changing duty, check each result
   int stall_phase = 0;
   int ready_pct   = 100;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result: pixel_value %h pixel_address %h",
                   rsp_payload.pixel_value, rsp_payload.pixel_address);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_payload.pixel_value !== want.pixel_value) begin
               $error("pixel_value: expected %h, got %h",
                      want.pixel_value, rsp_payload.pixel_value);
               error_count++;
            end
            if (rsp_payload.pixel_address !== want.pixel_address) begin
               $error("pixel_address: expected %h, got %h",
                      want.pixel_address, rsp_payload.pixel_address);
               error_count++;
            end
         end
      end
      stall_phase = stall_phase + 1;
      if (stall_phase == 150) begin
         stall_phase = 0;
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
         endcase
      end
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
   end

   // timeout
   initial begin
      #5_000_000;
      $display("** pixel_resolve_tonemap_pack_unit: FAILED **");
      $finish;
   end

   // stimulus phases
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at reset settings
      pending_items.push_back(make_item(0, 0, 0, 0, 0));
      pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                        12'hFFF, 12'hFFF));
      pending_items.push_back(make_item(32'h0001_0000, 32'h0000_FFFF, 32'h0000_8000,
                                        12'hFFF, 0));
      pending_items.push_back(make_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                                        0, 12'hFFF));
      pending_items.push_back(make_item(32'h0000_4000, 32'h0000_0001, 32'h0001_0001,
                                        12'h555, 12'hAAA));
      drain();

      // directed curves and special cases
      apply_settings(16'd0, 1'b0, 16'd0, CURVE_POWER);
      pending_items.push_back(make_item(32'h0000_8000, 32'h0000_8000, 32'h0001_0000,
                                        1, 1));
      pending_items.push_back(make_item(32'h0000_0100, 32'h0000_0001, 32'hFFFF_FFFF,
                                        2, 3));
      drain();
      apply_settings(16'd1, 1'b0, 16'd256, CURVE_PASS);
      pending_items.push_back(make_item(32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000,
                                        5, 7));
      drain();
      apply_settings(16'd1, 1'b0, 16'd256, CURVE_SPARE);
      pending_items.push_back(make_item(32'h0000_8000, 32'h0000_FFFF, 32'h0001_0000,
                                        5, 7));
      drain();
      apply_settings(16'd1, 1'b1, 16'hFFFF, CURVE_SQRT);
      pending_items.push_back(make_item(32'h000F_FFFF, 32'h0010_0000, 32'h0000_0100,
                                        9, 9));
      pending_items.push_back(make_item(32'h0000_1000, 32'h0001_0000, 0, 9, 10));
      drain();
      apply_settings(16'd65535, 1'b1, 16'd256, CURVE_POWER);
      pending_items.push_back(make_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                        12'hFFF, 12'hFFF));
      drain();

      // random phases over a spread of settings
      for (int p = 0; p < 12; p++) begin
         logic [15:0] n, g;
         logic [1:0]  c;
         logic        en;
         case (p % 4)
            0: n = 16'd1;
            1: n = 16'd0;
            2: n = 16'd65535;
            default: n = 16'($urandom_range(2, 300));
         endcase
         case (p % 3)
            0: g = 16'd256;
            1: g = (p < 6) ? 16'hFFFF : 16'd0;
            default: g = 16'($urandom);
         endcase
         en = p[0] ^ p[2];
         c  = 2'(p % 4);
         apply_settings(n, en, g, c);
         for (int i = 0; i < 104; i++) pending_items.push_back(random_item());
         drain();
      end

      if (error_count == 0) begin
         $display("** pixel_resolve_tonemap_pack_unit: PASSED **");
      end else begin
         $display("** pixel_resolve_tonemap_pack_unit: FAILED **");
      end
      $finish;
   end

endmodule
